// ===== src/mals_pkg.sv =====
// Shared types and constants of the memory-aware laxity scheduler.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none
package mals_pkg;
    localparam int TASKS = 16;
    localparam int STEPS = 64;
    localparam int TASK_W = $clog2(TASKS);
    localparam int STEP_W = $clog2(STEPS);
    localparam int CNT_W = $clog2(TASKS + 1);
    localparam int LEN_W = 7;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_LOAD_TASK = 2'd1;
    localparam logic [1:0] ACT_LOAD_MEM = 2'd2;
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    localparam logic [1:0] REG_MEM_WEIGHT = 2'd0;
    localparam logic [1:0] REG_TASK_COUNT = 2'd1;

    localparam logic [15:0] WEIGHT_RESET = 16'd1000;
    localparam logic [4:0] COUNT_RESET = 5'd1;
    localparam logic signed [31:0] DL_FLOOR = 32'sh8000_0000;

    typedef struct packed {
        logic [15:0]      rel;
        logic [31:0]      dl;
        logic [LEN_W-1:0] len;
    } task_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;
endpackage
`default_nettype wire

// ===== src/memory_aware_laxity_scheduler.sv =====
// Top level of the memory-aware least-laxity scheduler.
// Depends on mals_pkg for types and constants.
// Sequencing: a load item goes straight to the response state; a tick item
// first makes one pass over the entries in use of the task table memory,
// one entry per cycle through a two-stage priority pipeline, then a finish step.
// Throughput: one item at a time; the next is accepted while a result waits.
// Reset: synchronous active-low aresetn clears flags, counters and totals;
// the table memories hold undefined data until loaded.
`timescale 1ns / 1ps
`default_nettype none
module memory_aware_laxity_scheduler
    import mals_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // task_id, step_index, release_tick, deadline, task_length, mem_value
    input  wire logic [71:0] s_tdata,
    // action
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // picked_valid, picked_task, task_done, miss_total, memory_now, memory_worst, all_done
    output logic [79:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    logic [TASK_W-1:0] in_id;
    logic [STEP_W-1:0] in_step;
    logic [15:0] in_rel, in_dl, in_mem;
    logic [LEN_W-1:0] in_len;
    assign in_id   = s_tdata[3:0];
    assign in_step = s_tdata[9:4];
    assign in_rel  = s_tdata[25:10];
    assign in_dl   = s_tdata[41:26];
    assign in_len  = s_tdata[48:42];
    assign in_mem  = s_tdata[64:49];

    state_t state_reg, state_next;
    logic [15:0] weight_reg;
    logic [4:0]  count_reg;
    logic [CNT_W-1:0] used_n;

    task_entry_t tt_mem [TASKS];
    logic [15:0] inc_mem [TASKS*STEPS];
    task_entry_t tt_rd_reg;
    logic [15:0] inc_rd_reg;

    logic [LEN_W-1:0] steps_reg [TASKS];
    logic [TASKS-1:0] active_reg, fin_reg, missed_reg;
    logic [31:0] tick_reg;
    logic signed [31:0] total_reg;
    logic [30:0] peak_reg;

    logic [CNT_W-1:0] iss_reg;
    logic p1_v_reg, p1_zero_reg;
    logic [TASK_W-1:0] p1_idx_reg;
    logic p2_v_reg, p2_cand_reg;
    logic [TASK_W-1:0] p2_idx_reg;
    logic signed [32:0] p2_m1_reg;
    logic signed [42:0] p2_m2_reg;
    logic signed [15:0] p2_inc_reg;
    logic signed [31:0] p2_dl_reg;
    logic [LEN_W-1:0] p2_len_reg, p2_steps_reg;

    logic found_reg;
    logic [TASK_W-1:0] best_idx_reg;
    logic signed [43:0] best_p_reg;
    logic signed [15:0] best_inc_reg;
    logic signed [31:0] best_dl_reg;
    logic [LEN_W-1:0] best_len_reg, best_steps_reg;

    logic res_valid_reg, res_done_reg;
    logic [TASK_W-1:0] res_task_reg;
    logic m_valid_reg;
    logic [79:0] m_data_reg;

    logic s_acc, issue;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb begin
        if (count_reg == 5'd0) begin
            used_n = CNT_W'(1);
        end else if (count_reg > 5'(TASKS)) begin
            used_n = CNT_W'(TASKS);
        end else begin
            used_n = CNT_W'(count_reg);
        end
    end

    assign issue = (state_reg == ST_SCAN) && (iss_reg < used_n);

    // Stage 1: release check, laxity and the two products of one entry.
    logic [LEN_W-1:0] s1_steps;
    logic s1_act, s1_fin, s1_rel, s1_act_new, s1_cand;
    logic signed [33:0] s1_lax;
    logic signed [31:0] s1_dl, s1_dl_new;
    logic signed [15:0] s1_inc;
    logic [LEN_W-1:0] s1_rem;
    always_comb begin
        s1_steps = steps_reg[p1_idx_reg];
        s1_act = active_reg[p1_idx_reg];
        s1_fin = fin_reg[p1_idx_reg];
        s1_dl = $signed(tt_rd_reg.dl);
        s1_rel = !s1_act && !s1_fin && (tick_reg == {16'd0, tt_rd_reg.rel});
        s1_lax = 34'(s1_dl) - $signed({27'd0, tt_rd_reg.len})
                 + $signed({27'd0, s1_steps});
        s1_act_new = s1_act || (s1_rel && (tt_rd_reg.len != '0));
        s1_cand = s1_act_new && (s1_steps < tt_rd_reg.len);
        s1_dl_new = (s1_act_new && (s1_dl != DL_FLOOR)) ? s1_dl - 32'sd1 : s1_dl;
        s1_inc = p1_zero_reg ? 16'sd0 : $signed(inc_rd_reg);
        s1_rem = tt_rd_reg.len - s1_steps;
    end

    logic signed [43:0] s2_sum;
    assign s2_sum = 44'(p2_m1_reg) + 44'(p2_m2_reg);

    // Finish step of the picked task.
    logic [LEN_W-1:0] fin_steps;
    logic signed [33:0] fin_lax;
    logic signed [32:0] fin_total;
    logic signed [31:0] fin_sat;
    always_comb begin
        fin_steps = best_steps_reg + LEN_W'(1);
        fin_lax = 34'(best_dl_reg) - $signed({27'd0, best_len_reg})
                  + $signed({27'd0, fin_steps});
        fin_total = 33'(total_reg) + 33'(best_inc_reg);
        if (fin_total > 33'sh0_7FFF_FFFF) begin
            fin_sat = 32'sh7FFF_FFFF;
        end else if (fin_total < -33'sh0_8000_0000) begin
            fin_sat = DL_FLOOR;
        end else begin
            fin_sat = fin_total[31:0];
        end
    end

    logic [CNT_W-1:0] miss_cnt;
    logic all_fin;
    always_comb begin
        miss_cnt = '0;
        all_fin = 1'b1;
        for (int i = 0; i < TASKS; i++) begin
            if (CNT_W'(i) < used_n) begin
                miss_cnt = miss_cnt + CNT_W'(missed_reg[i]);
                if (!fin_reg[i]) begin
                    all_fin = 1'b0;
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = (s_tuser == ACT_TICK) ? ST_SCAN : ST_RESP;
                end
            end
            ST_SCAN: begin
                if (!issue && !p1_v_reg && !p2_v_reg) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: state_next = ST_RESP;
            ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memories: one read and one write port each.
    always_ff @(posedge aclk) begin
        if (issue) begin
            tt_rd_reg <= tt_mem[iss_reg[TASK_W-1:0]];
            inc_rd_reg <= inc_mem[{iss_reg[TASK_W-1:0],
                                   steps_reg[iss_reg[TASK_W-1:0]][STEP_W-1:0]}];
        end
        if (s_acc && s_tuser == ACT_LOAD_TASK) begin
            tt_mem[in_id] <= '{rel: in_rel, dl: {16'd0, in_dl}, len: in_len};
        end else if (p1_v_reg) begin
            tt_mem[p1_idx_reg] <= '{rel: tt_rd_reg.rel, dl: s1_dl_new, len: tt_rd_reg.len};
        end
        if (s_acc && s_tuser == ACT_LOAD_MEM) begin
            inc_mem[{in_id, in_step}] <= in_mem;
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge aclk) begin
        p1_idx_reg <= iss_reg[TASK_W-1:0];
        p1_zero_reg <= (steps_reg[iss_reg[TASK_W-1:0]] >= LEN_W'(STEPS));
        p2_idx_reg <= p1_idx_reg;
        p2_cand_reg <= s1_cand;
        p2_m1_reg <= 33'($signed({1'b0, weight_reg})) * 33'(s1_inc);
        p2_m2_reg <= 43'($signed({1'b0, s1_rem})) * 43'(s1_lax);
        p2_inc_reg <= s1_inc;
        p2_dl_reg <= s1_dl_new;
        p2_len_reg <= tt_rd_reg.len;
        p2_steps_reg <= s1_steps;
        if (p2_v_reg && p2_cand_reg && (!found_reg || s2_sum < best_p_reg)) begin
            best_idx_reg <= p2_idx_reg;
            best_p_reg <= s2_sum;
            best_inc_reg <= p2_inc_reg;
            best_dl_reg <= p2_dl_reg;
            best_len_reg <= p2_len_reg;
            best_steps_reg <= p2_steps_reg;
        end
        if (state_reg == ST_RESP && (!m_valid_reg || m_tready)) begin
            m_data_reg <= {5'd0, all_fin, peak_reg, total_reg, miss_cnt,
                           res_done_reg, res_task_reg, res_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            weight_reg <= WEIGHT_RESET;
            count_reg <= COUNT_RESET;
            active_reg <= '0;
            fin_reg <= '0;
            missed_reg <= '0;
            for (int i = 0; i < TASKS; i++) begin
                steps_reg[i] <= '0;
            end
            tick_reg <= '0;
            total_reg <= '0;
            peak_reg <= '0;
            iss_reg <= '0;
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            found_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            res_done_reg <= 1'b0;
            res_task_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MEM_WEIGHT: weight_reg <= cfg_data;
                    REG_TASK_COUNT: count_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_RESP && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            p1_v_reg <= issue;
            p2_v_reg <= p1_v_reg;
            if (issue) begin
                iss_reg <= iss_reg + CNT_W'(1);
            end
            if (s_acc) begin
                iss_reg <= '0;
                found_reg <= 1'b0;
                res_valid_reg <= 1'b0;
                res_done_reg <= 1'b0;
                res_task_reg <= '0;
                if (s_tuser == ACT_LOAD_TASK) begin
                    steps_reg[in_id] <= '0;
                    active_reg[in_id] <= 1'b0;
                    fin_reg[in_id] <= 1'b0;
                    missed_reg[in_id] <= 1'b0;
                end
            end
            if (p1_v_reg) begin
                active_reg[p1_idx_reg] <= s1_act_new;
                if (s1_rel) begin
                    if (s1_lax < 0) begin
                        missed_reg[p1_idx_reg] <= 1'b1;
                    end
                    if (tt_rd_reg.len == '0) begin
                        fin_reg[p1_idx_reg] <= 1'b1;
                    end
                end
            end
            if (p2_v_reg && p2_cand_reg) begin
                found_reg <= 1'b1;
            end
            if (state_reg == ST_FIN) begin
                tick_reg <= tick_reg + 32'd1;
                if (found_reg) begin
                    total_reg <= fin_sat;
                    if (fin_sat > $signed({1'b0, peak_reg})) begin
                        peak_reg <= fin_sat[30:0];
                    end
                    steps_reg[best_idx_reg] <= fin_steps;
                    res_valid_reg <= 1'b1;
                    res_task_reg <= best_idx_reg;
                    if (fin_steps >= best_len_reg) begin
                        res_done_reg <= 1'b1;
                        fin_reg[best_idx_reg] <= 1'b1;
                        active_reg[best_idx_reg] <= 1'b0;
                        if (fin_lax < 0) begin
                            missed_reg[best_idx_reg] <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    a_pick_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && found_reg) |-> (CNT_W'(best_idx_reg) < used_n))
        else $error("picked entry lies outside the entries in use");
    a_miss_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        miss_cnt <= used_n)
        else $error("miss count exceeds the entries in use");
    a_peak_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= $signed({1'b0, peak_reg}))
        else $error("memory total above its recorded peak");
    a_scan_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> (!p1_v_reg && !p2_v_reg))
        else $error("finish step entered with the pipeline still busy");
endmodule
`default_nettype wire
